// ----- rtl/core/mccs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mccs_pkg : shared types and constants of the minimum coin change solver
// command codes, sequencer states and field widths
// ----------------------------------------------------------------------------
package mccs_pkg;

  localparam int unsigned MAX_COINS_DEF  = 16;
  localparam int unsigned MAX_AMOUNT_DEF = 16383;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned OPERAND_W = 16;
  localparam int unsigned MIN_W     = 14;

  // largest count the result field can carry
  localparam logic [MIN_W-1:0] COUNT_MAX = {MIN_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_SOLVE = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_FETCH,
    ST_CHECK,
    ST_RUN,
    ST_DRAIN,
    ST_FINAL,
    ST_RESULT
  } state_e;

endpackage

// ----- rtl/core/min_coin_change_solver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_coin_change_solver : fewest coins summing to an amount, unlimited use
// keeps a coin list and answers solve items with a table-driven sweep
// ----------------------------------------------------------------------------
// clear and add items give no result
// a solve for amount A with N stored coins sweeps the table once per usable coin,
//   its run time set by the single write port of the best-count table
//   (one entry a cycle)
// an amount above MAX_AMOUNT skips the sweep and answers with the range flag
// reset empties the coin list and idles the sequencer; no clearing pass
module min_coin_change_solver #(
  parameter int unsigned MAX_COINS  = mccs_pkg::MAX_COINS_DEF,
  parameter int unsigned MAX_AMOUNT = mccs_pkg::MAX_AMOUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // item input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [mccs_pkg::CMD_W-1:0]     command_i,
  input  logic [mccs_pkg::OPERAND_W-1:0] operand_value_i,
  // result output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mccs_pkg::MIN_W-1:0]     min_coins_o,
  output logic                           reachable_o,
  output logic                           range_error_o
);

  // table index, coin count and coin index widths
  localparam int unsigned AW    = (MAX_AMOUNT > 1) ? $clog2(MAX_AMOUNT + 1) : 1;
  localparam int unsigned DEPTH = MAX_AMOUNT + 1;
  localparam int unsigned CW    = $clog2(MAX_COINS + 1);
  localparam int unsigned IW    = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
  // table entry width: every real count fits below the all-ones marker
  localparam int unsigned TW    = $clog2(MAX_AMOUNT + 2);
  localparam int unsigned XW    = (TW > mccs_pkg::MIN_W + 1) ? TW : mccs_pkg::MIN_W + 1;
  localparam logic [TW-1:0] UNREACHED = {TW{1'b1}};

  localparam int unsigned OW = mccs_pkg::OPERAND_W;

  mccs_pkg::state_e state_q, state_d;

  logic [CW-1:0] coin_count_q, coin_count_d;
  logic [CW-1:0] k_q, k_d;          // coin being swept
  logic [AW-1:0] a_q, a_d;          // table index being issued
  logic [AW-1:0] amount_q, amount_d;
  logic [AW-1:0] coin_q, coin_d;
  logic          rng_q, rng_d;

  // relaxation pipeline: read issued one cycle, update written the next
  logic          p_vld_q, p_vld_d;
  logic [AW-1:0] p_addr_q, p_addr_d;
  logic          p_fwd_q, p_fwd_d;
  logic [TW-1:0] new_q, new_d;      // last value written, forwarded for coin one

  // output register
  logic                       out_vld_q, out_vld_d;
  logic [mccs_pkg::MIN_W-1:0] min_q, min_d;
  logic                       reach_q, reach_d;
  logic                       rerr_q, rerr_d;

  // coin store memory
  logic [OW-1:0] coin_mem [MAX_COINS];
  logic          coin_we;
  logic [OW-1:0] coin_rd_q;

  // best-count table memory: one write, two registered reads
  logic [TW-1:0] best_mem [DEPTH];
  logic          t_we;
  logic [AW-1:0] t_waddr;
  logic [TW-1:0] t_wdata;
  logic [AW-1:0] t_ra0, t_ra1;
  logic [TW-1:0] rd0_q, rd1_q;

  // relaxation arithmetic
  logic [TW-1:0] prev;
  logic [TW-1:0] cand;
  logic [TW-1:0] relaxed;
  logic [XW-1:0] n_ext;

  logic in_acc;
  logic out_free;

  assign in_stall_o = (state_q != mccs_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_vld_q || !out_stall_i;

  // min(best[a], best[a-c] + 1), unreached entries never improve anything
  assign prev    = p_fwd_q ? new_q : rd1_q;
  assign cand    = prev + TW'(1);
  assign relaxed = ((prev != UNREACHED) && (cand < rd0_q)) ? cand : rd0_q;
  assign n_ext   = XW'(rd0_q);

  always_ff @(posedge clk_i) begin
    if (coin_we) begin
      coin_mem[coin_count_q[IW-1:0]] <= operand_value_i;
    end
    coin_rd_q <= coin_mem[k_q[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (t_we) begin
      best_mem[t_waddr] <= t_wdata;
    end
    rd0_q <= best_mem[t_ra0];
    rd1_q <= best_mem[t_ra1];
  end

  always_comb begin
    state_d      = state_q;
    coin_count_d = coin_count_q;
    k_d          = k_q;
    a_d          = a_q;
    amount_d     = amount_q;
    coin_d       = coin_q;
    rng_d        = rng_q;
    p_vld_d      = 1'b0;
    p_addr_d     = a_q;
    p_fwd_d      = 1'b0;
    new_d        = new_q;
    out_vld_d    = out_vld_q && out_stall_i;
    min_d        = min_q;
    reach_d      = reach_q;
    rerr_d       = rerr_q;
    coin_we      = 1'b0;
    t_we         = p_vld_q;
    t_waddr      = p_addr_q;
    t_wdata      = relaxed;
    t_ra0        = amount_q;
    t_ra1        = amount_q;

    if (p_vld_q) begin
      new_d = relaxed;
    end

    case (state_q)
      mccs_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (mccs_pkg::cmd_e'(command_i))
            mccs_pkg::CMD_CLEAR: begin
              coin_count_d = '0;
            end
            mccs_pkg::CMD_ADD: begin
              if ((operand_value_i != '0) && (coin_count_q < CW'(MAX_COINS))) begin
                coin_we      = 1'b1;
                coin_count_d = coin_count_q + CW'(1);
              end
            end
            mccs_pkg::CMD_SOLVE: begin
              amount_d = operand_value_i[AW-1:0];
              a_d      = '0;
              if (operand_value_i > OW'(MAX_AMOUNT)) begin
                rng_d   = 1'b1;
                state_d = mccs_pkg::ST_RESULT;
              end else begin
                rng_d   = 1'b0;
                state_d = mccs_pkg::ST_INIT;
              end
            end
            default: begin
              // unused command code, nothing changes
            end
          endcase
        end
      end

      // zero at amount zero, unreached everywhere else up to the amount
      mccs_pkg::ST_INIT: begin
        t_we    = 1'b1;
        t_waddr = a_q;
        t_wdata = (a_q == '0) ? '0 : UNREACHED;
        if (a_q == amount_q) begin
          k_d     = '0;
          state_d = mccs_pkg::ST_FETCH;
        end else begin
          a_d = a_q + AW'(1);
        end
      end

      mccs_pkg::ST_FETCH: begin
        if (k_q == coin_count_q) begin
          state_d = mccs_pkg::ST_FINAL;
        end else begin
          state_d = mccs_pkg::ST_CHECK;
        end
      end

      // skip coins that cannot fit the amount
      mccs_pkg::ST_CHECK: begin
        if ((coin_rd_q == '0) || (coin_rd_q > OW'(amount_q))) begin
          k_d     = k_q + CW'(1);
          state_d = mccs_pkg::ST_FETCH;
        end else begin
          coin_d  = coin_rd_q[AW-1:0];
          a_d     = coin_rd_q[AW-1:0];
          state_d = mccs_pkg::ST_RUN;
        end
      end

      // issue reads of best[a] and best[a-c]; update lands next cycle
      mccs_pkg::ST_RUN: begin
        t_ra0    = a_q;
        t_ra1    = a_q - coin_q;
        p_vld_d  = 1'b1;
        p_addr_d = a_q;
        // with a coin of one, best[a-1] is still being written
        p_fwd_d  = (coin_q == AW'(1)) && (a_q != coin_q);
        if (a_q == amount_q) begin
          state_d = mccs_pkg::ST_DRAIN;
        end else begin
          a_d = a_q + AW'(1);
        end
      end

      mccs_pkg::ST_DRAIN: begin
        k_d     = k_q + CW'(1);
        state_d = mccs_pkg::ST_FETCH;
      end

      mccs_pkg::ST_FINAL: begin
        state_d = mccs_pkg::ST_RESULT;
      end

      // rd0 holds best[amount]; hand over once the output register is free
      mccs_pkg::ST_RESULT: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          if (rng_q) begin
            min_d   = '0;
            reach_d = 1'b0;
            rerr_d  = 1'b1;
          end else if (rd0_q == UNREACHED) begin
            min_d   = '0;
            reach_d = 1'b0;
            rerr_d  = 1'b0;
          end else begin
            min_d   = (n_ext > XW'(mccs_pkg::COUNT_MAX)) ? mccs_pkg::COUNT_MAX
                                                         : n_ext[mccs_pkg::MIN_W-1:0];
            reach_d = 1'b1;
            rerr_d  = 1'b0;
          end
          state_d = mccs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = mccs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mccs_pkg::ST_IDLE;
      coin_count_q <= '0;
      k_q          <= '0;
      p_vld_q      <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      coin_count_q <= coin_count_d;
      k_q          <= k_d;
      p_vld_q      <= p_vld_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    amount_q <= amount_d;
    coin_q   <= coin_d;
    rng_q    <= rng_d;
    p_addr_q <= p_addr_d;
    p_fwd_q  <= p_fwd_d;
    new_q    <= new_d;
    min_q    <= min_d;
    reach_q  <= reach_d;
    rerr_q   <= rerr_d;
  end

  assign out_valid_o   = out_vld_q;
  assign min_coins_o   = min_q;
  assign reachable_o   = reach_q;
  assign range_error_o = rerr_q;

endmodule
